// ===== rtl/assert_macros.svh =====
// assertion helpers for the checker in odo_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ODO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property that also covers the reset cycles
`define ODO_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/odo_pkg.sv =====
package odo_pkg;

    // job sequence run for every item
    typedef enum logic [3:0] {
        J_SW,
        J_DW,
        J_CT,
        J_CDT,
        J_CTDT,
        J_LIN,
        J_PX,
        J_PY,
        J_HD,
        J_LS,
        J_TR,
        J_RL,
        J_RR,
        J_AL,
        J_AR
    } t_job;

    // command word from the controller to the datapath
    typedef struct packed {
        logic       load_item;
        logic       op_load;
        logic       mul_step;
        logic       div_step;
        logic       fin;
        logic       cor_step;
        logic       out_load;
        t_job       job;
        logic [6:0] idx;
    } t_cmd;

    localparam int CORDIC_STEPS = 30;

    // register indexes
    localparam logic [1:0] REG_CPR   = 2'd0;
    localparam logic [1:0] REG_CIRC  = 2'd1;
    localparam logic [1:0] REG_TRACK = 2'd2;

    // arctangent of 2^-i, 2^32 per turn
    function automatic logic [29:0] atan_turn(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            5'd24: v = 30'd41;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/differential_drive_odometry.sv =====
// differential-drive odometry
// input stream: one encoder report per item (relative and absolute counts of
// both wheels, elapsed milliseconds); output stream: one pose and speed item
// per report, time_fault on tuser.
// configuration: apb registers counts_per_rev (0x0), wheel_circumference_um
// (0x4), track_width_um (0x8); write them only while no report is in flight.
// each report runs through a bit-serial shift-add multiplier, a one bit per
// cycle restoring divider and a 30 step cordic, all driven by one sequencer.
// the next report is taken once the sequencer is back in idle, so a report is
// not accepted before the previous one has reached the output register.
// the result sits in an output register: a stalled receiver does not block
// acceptance of the next report, only the hand-over of its finished result.
// reset zeroes the pose and heading, loads the register defaults and drops
// output valid.
module differential_drive_odometry #(
    parameter int ANGLE_BITS    = 24,
    parameter int POSITION_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // right_delta_counts, left_delta_counts, right_abs_count, left_abs_count,
    // elapsed_ms
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // pos_x_um, pos_y_um, heading, linear_speed_um_s, turn_rate_urad_s,
    // left_rpm_centi, right_rpm_centi, left_wheel_angle, right_wheel_angle
    output logic [263:0] m_axis_tdata,
    // time_fault
    output logic [0:0]   m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    odo_pkg::t_cmd w_cmd;
    logic [23:0]   w_rdata;
    logic          w_fault;
    logic          w_cfg_we;

    // apb access, no wait states
    assign pready   = 1'b1;
    assign w_cfg_we = psel & penable & pwrite;
    assign prdata   = {8'd0, w_rdata};
    assign m_axis_tuser = w_fault;

    odo_ctrl #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    odo_dp #(
        .ANGLE_BITS    (ANGLE_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_data   (s_axis_tdata),
        .i_cfg_we    (w_cfg_we),
        .i_cfg_idx   (paddr[3:2]),
        .i_cfg_wdata (pwdata[23:0]),
        .o_cfg_rdata (w_rdata),
        .o_out_data  (m_axis_tdata),
        .o_out_fault (w_fault)
    );

endmodule

// ===== rtl/odo_ctrl.sv =====
module odo_ctrl #(
    parameter int ANGLE_BITS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output odo_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_DIV,
        S_FIN,
        S_COR,
        S_DONE
    } t_state;

    localparam logic [6:0] ANG_DIV_BITS = 7'(33 + ANGLE_BITS);

    t_state          r_state;
    odo_pkg::t_job   r_job;
    logic [6:0]      r_cnt;
    logic            r_ovalid;
    logic            w_out_fire;
    logic [6:0]      w_mbits;
    logic [6:0]      w_dbits;

    // multiplier bits per job
    function automatic logic [6:0] mul_bits(input odo_pkg::t_job j);
        logic [6:0] n;
        case (j)
            odo_pkg::J_SW, odo_pkg::J_DW, odo_pkg::J_CT: n = 7'd24;
            odo_pkg::J_CDT, odo_pkg::J_CTDT:             n = 7'd16;
            odo_pkg::J_PX, odo_pkg::J_PY:                n = 7'd34;
            odo_pkg::J_HD:                               n = 7'd64;
            odo_pkg::J_LS:                               n = 7'd10;
            odo_pkg::J_TR:                               n = 7'd30;
            odo_pkg::J_RL, odo_pkg::J_RR:                n = 7'd27;
            default:                                     n = 7'd1;
        endcase
        return n;
    endfunction

    // numerator bits per job, zero when there is no division
    function automatic logic [6:0] div_bits(input odo_pkg::t_job j);
        logic [6:0] n;
        case (j)
            odo_pkg::J_LIN:               n = 7'd50;
            odo_pkg::J_HD:                n = 7'd112;
            odo_pkg::J_LS:                n = 7'd59;
            odo_pkg::J_TR:                n = 7'd79;
            odo_pkg::J_RL, odo_pkg::J_RR: n = 7'd51;
            odo_pkg::J_AL, odo_pkg::J_AR: n = ANG_DIV_BITS;
            default:                      n = 7'd0;
        endcase
        return n;
    endfunction

    assign w_mbits    = mul_bits(r_job);
    assign w_dbits    = div_bits(r_job);
    assign w_out_fire = (r_state == S_DONE) && (!r_ovalid || i_out_ready);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    // sequencer state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_job    <= odo_pkg::J_SW;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_out_fire) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_job   <= odo_pkg::J_SW;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_cnt   <= w_mbits;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_cnt == 7'd1) begin
                        if (w_dbits != 7'd0) begin
                            r_cnt   <= w_dbits;
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end else begin
                        r_cnt <= r_cnt - 7'd1;
                    end
                end
                S_DIV: begin
                    if (r_cnt == 7'd1) begin
                        r_state <= S_FIN;
                    end else begin
                        r_cnt <= r_cnt - 7'd1;
                    end
                end
                S_FIN: begin
                    if (r_job == odo_pkg::J_LIN) begin
                        r_cnt   <= 7'(odo_pkg::CORDIC_STEPS);
                        r_state <= S_COR;
                    end else if (r_job == odo_pkg::J_AR) begin
                        r_state <= S_DONE;
                    end else begin
                        r_job   <= odo_pkg::t_job'(4'(r_job) + 4'd1);
                        r_state <= S_LOAD;
                    end
                end
                S_COR: begin
                    if (r_cnt == 7'd1) begin
                        r_job   <= odo_pkg::J_PX;
                        r_state <= S_LOAD;
                    end else begin
                        r_cnt <= r_cnt - 7'd1;
                    end
                end
                S_DONE: begin
                    if (w_out_fire) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // command decode
    always_comb begin
        o_cmd           = '0;
        o_cmd.job       = r_job;
        o_cmd.load_item = (r_state == S_IDLE) && i_in_valid;
        o_cmd.op_load   = (r_state == S_LOAD);
        o_cmd.mul_step  = (r_state == S_MUL);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.fin       = (r_state == S_FIN);
        o_cmd.cor_step  = (r_state == S_COR);
        o_cmd.out_load  = w_out_fire;
        if (r_state == S_DIV) begin
            o_cmd.idx = r_cnt - 7'd1;
        end else if (r_state == S_COR) begin
            o_cmd.idx = 7'(odo_pkg::CORDIC_STEPS) - r_cnt;
        end
    end

endmodule

// ===== rtl/odo_dp.sv =====
module odo_dp #(
    parameter int ANGLE_BITS    = 24,
    parameter int POSITION_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  odo_pkg::t_cmd i_cmd,
    input  logic [127:0]  i_in_data,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [23:0]   i_cfg_wdata,
    output logic [23:0]   o_cfg_rdata,
    output logic [263:0]  o_out_data,
    output logic          o_out_fault
);

    localparam int AB = ANGLE_BITS;
    localparam int PB = POSITION_BITS;
    localparam logic [6:0]  HD_SHIFT = 7'(65 - ANGLE_BITS);
    localparam logic [33:0] CORDIC_GAIN = 34'd652032874;
    localparam logic [63:0] INV_PI_Q64  = 64'h517CC1B727220A95;
    localparam logic [63:0] LIN_K  = 64'd1000;
    localparam logic [63:0] TURN_K = 64'd1000000000;
    localparam logic [63:0] RPM_K  = 64'd120000000;

    // configuration
    logic [23:0] r_cpr, r_circ, r_track;
    // item fields
    logic signed [23:0] r_dr, r_dl;
    logic signed [31:0] r_ar, r_al;
    logic [15:0]        r_dt;
    // products kept over the item
    logic [48:0] r_sw, r_dw;
    logic [47:0] r_ct;
    logic [39:0] r_cdt;
    logic [63:0] r_ctdt;
    logic [48:0] r_lin_mag;
    logic        r_lin_neg;
    // cordic
    logic signed [33:0] r_cx, r_cy, r_cz;
    logic               r_flip;
    // pose
    logic [PB-1:0] r_x, r_y;
    logic [AB-1:0] r_hd;
    // results
    logic [31:0]   r_ls, r_tr, r_rl, r_rr;
    logic [AB-1:0] r_aal, r_aar;
    // shift-add multiplier and restoring divider
    logic [127:0] r_ma, r_num;
    logic [63:0]  r_mb, r_rem, r_div;
    logic [79:0]  r_quo;
    logic         r_ovf;
    // output register
    logic [263:0] r_o_data;
    logic         r_o_fault;

    logic signed [24:0] w_sum, w_diff;
    logic [24:0]  w_sum_mag, w_diff_mag;
    logic [23:0]  w_dl_mag, w_dr_mag, w_cpr, w_trk;
    logic [31:0]  w_al_mag, w_ar_mag;
    logic [33:0]  w_cx_mag, w_cy_mag;
    logic         w_cs_neg, w_sn_neg;
    logic [127:0] w_ma;
    logic [63:0]  w_mb, w_div;
    logic [79:0]  w_q, w_shifted, w_rnd;
    logic [80:0]  w_rnd_ext;
    logic         w_ovf;
    logic [6:0]   w_shift;
    logic         w_pneg, w_aneg;
    logic [PB-1:0] w_pinc;
    logic [AB-1:0] w_ainc;
    logic [64:0]  w_trial;
    logic         w_ge;
    logic [31:0]  w_th, w_th2;
    logic         w_flip;
    logic signed [33:0] w_dx, w_dy, w_at;
    logic         w_dt_zero;

    function automatic logic [31:0] sat32(input logic [79:0] v, input logic ovf,
                                          input logic neg);
        logic [79:0] lim;
        logic [79:0] m;
        lim = neg ? 80'h8000_0000 : 80'h7FFF_FFFF;
        m = (ovf || (v > lim)) ? lim : v;
        return neg ? 32'(-m) : m[31:0];
    endfunction

    // field arithmetic
    assign w_sum      = 25'(r_dl) + 25'(r_dr);
    assign w_diff     = 25'(r_dr) - 25'(r_dl);
    assign w_sum_mag  = w_sum[24] ? 25'(-w_sum) : 25'(w_sum);
    assign w_diff_mag = w_diff[24] ? 25'(-w_diff) : 25'(w_diff);
    assign w_dl_mag   = r_dl[23] ? 24'(-r_dl) : 24'(r_dl);
    assign w_dr_mag   = r_dr[23] ? 24'(-r_dr) : 24'(r_dr);
    assign w_al_mag   = r_al[31] ? 32'(-r_al) : 32'(r_al);
    assign w_ar_mag   = r_ar[31] ? 32'(-r_ar) : 32'(r_ar);
    assign w_cpr      = (r_cpr == 24'd0) ? 24'd1 : r_cpr;
    assign w_trk      = (r_track == 24'd0) ? 24'd1 : r_track;
    assign w_cx_mag   = r_cx[33] ? 34'(-r_cx) : 34'(r_cx);
    assign w_cy_mag   = r_cy[33] ? 34'(-r_cy) : 34'(r_cy);
    assign w_cs_neg   = r_flip ^ r_cx[33];
    assign w_sn_neg   = r_flip ^ r_cy[33];
    assign w_dt_zero  = (r_dt == 16'd0);

    // operand selection per job
    always_comb begin
        w_ma  = '0;
        w_mb  = '0;
        w_div = 64'd1;
        case (i_cmd.job)
            odo_pkg::J_SW:   begin w_ma = 128'(w_sum_mag);  w_mb = 64'(r_circ); end
            odo_pkg::J_DW:   begin w_ma = 128'(w_diff_mag); w_mb = 64'(r_circ); end
            odo_pkg::J_CT:   begin w_ma = 128'(w_cpr);      w_mb = 64'(w_trk);  end
            odo_pkg::J_CDT:  begin w_ma = 128'(w_cpr);      w_mb = 64'(r_dt);   end
            odo_pkg::J_CTDT: begin w_ma = 128'(r_ct);       w_mb = 64'(r_dt);   end
            odo_pkg::J_LIN: begin
                w_ma = 128'(r_sw) << 1;
                w_mb = 64'd1;
                w_div = 64'(w_cpr);
            end
            odo_pkg::J_PX: begin w_ma = 128'(r_lin_mag) << 1; w_mb = 64'(w_cx_mag); end
            odo_pkg::J_PY: begin w_ma = 128'(r_lin_mag) << 1; w_mb = 64'(w_cy_mag); end
            odo_pkg::J_HD: begin
                w_ma = 128'(r_dw) << 1;
                w_mb = INV_PI_Q64;
                w_div = 64'(r_ct);
            end
            odo_pkg::J_LS: begin
                w_ma = 128'(r_sw) << 1;
                w_mb = LIN_K;
                w_div = 64'(r_cdt);
            end
            odo_pkg::J_TR: begin
                w_ma = 128'(r_dw) << 1;
                w_mb = TURN_K;
                w_div = r_ctdt;
            end
            odo_pkg::J_RL: begin
                w_ma = 128'(w_dl_mag) << 1;
                w_mb = RPM_K;
                w_div = 64'(r_cdt);
            end
            odo_pkg::J_RR: begin
                w_ma = 128'(w_dr_mag) << 1;
                w_mb = RPM_K;
                w_div = 64'(r_cdt);
            end
            odo_pkg::J_AL: begin
                w_ma = 128'(w_al_mag) << (AB + 1);
                w_mb = 64'd1;
                w_div = 64'(w_cpr);
            end
            odo_pkg::J_AR: begin
                w_ma = 128'(w_ar_mag) << (AB + 1);
                w_mb = 64'd1;
                w_div = 64'(w_cpr);
            end
            default: ;
        endcase
    end

    // quotient scaling and rounding, ties away from zero on magnitudes
    always_comb begin
        if (i_cmd.job == odo_pkg::J_PX || i_cmd.job == odo_pkg::J_PY) begin
            w_q   = r_num[79:0];
            w_ovf = |r_num[127:80];
        end else begin
            w_q   = r_quo;
            w_ovf = r_ovf;
        end
        case (i_cmd.job)
            odo_pkg::J_LIN, odo_pkg::J_LS: w_shift = 7'd1;
            odo_pkg::J_PX, odo_pkg::J_PY:  w_shift = 7'd30;
            odo_pkg::J_HD:                 w_shift = HD_SHIFT;
            default:                       w_shift = 7'd0;
        endcase
        w_shifted = w_q >> w_shift;
        w_rnd_ext = {1'b0, w_shifted} + 81'd1;
        w_rnd     = w_rnd_ext[80:1];
        w_pneg    = (i_cmd.job == odo_pkg::J_PX) ? (r_lin_neg ^ w_cs_neg)
                                                 : (r_lin_neg ^ w_sn_neg);
        case (i_cmd.job)
            odo_pkg::J_AL: w_aneg = r_al[31];
            odo_pkg::J_AR: w_aneg = r_ar[31];
            default:       w_aneg = w_diff[24];
        endcase
        w_pinc = w_pneg ? -w_rnd[PB-1:0] : w_rnd[PB-1:0];
        w_ainc = w_aneg ? -w_rnd[AB-1:0] : w_rnd[AB-1:0];
    end

    // divider trial subtract
    assign w_trial = {r_rem, r_num[i_cmd.idx]};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    // cordic start angle, folded into the right half plane
    assign w_th   = 32'(r_hd) << (32 - AB);
    assign w_flip = w_th[31] ^ w_th[30];
    assign w_th2  = {w_th[31] ^ w_flip, w_th[30:0]};
    assign w_dx   = r_cy >>> i_cmd.idx[4:0];
    assign w_dy   = r_cx >>> i_cmd.idx[4:0];
    assign w_at   = signed'(34'(odo_pkg::atan_turn(i_cmd.idx[4:0])));

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpr   <= 24'd200000;
            r_circ  <= 24'd565486;
            r_track <= 24'd815000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                odo_pkg::REG_CPR:   r_cpr   <= i_cfg_wdata;
                odo_pkg::REG_CIRC:  r_circ  <= i_cfg_wdata;
                odo_pkg::REG_TRACK: r_track <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_cfg_idx)
            odo_pkg::REG_CPR:   o_cfg_rdata = r_cpr;
            odo_pkg::REG_CIRC:  o_cfg_rdata = r_circ;
            odo_pkg::REG_TRACK: o_cfg_rdata = r_track;
            default:            o_cfg_rdata = 24'd0;
        endcase
    end

    // pose state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x  <= '0;
            r_y  <= '0;
            r_hd <= '0;
        end else if (i_cmd.fin) begin
            case (i_cmd.job)
                odo_pkg::J_PX: r_x  <= r_x + w_pinc;
                odo_pkg::J_PY: r_y  <= r_y + w_pinc;
                odo_pkg::J_HD: r_hd <= r_hd + w_ainc;
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_dr   <= i_in_data[23:0];
            r_dl   <= i_in_data[47:24];
            r_ar   <= i_in_data[79:48];
            r_al   <= i_in_data[111:80];
            r_dt   <= i_in_data[127:112];
            r_cx   <= CORDIC_GAIN;
            r_cy   <= '0;
            r_cz   <= 34'(signed'(w_th2));
            r_flip <= w_flip;
        end
        if (i_cmd.op_load) begin
            r_num <= '0;
            r_ma  <= w_ma;
            r_mb  <= w_mb;
            r_rem <= '0;
            r_quo <= '0;
            r_ovf <= 1'b0;
            r_div <= w_div;
        end
        // shift-add multiply, one multiplier bit a cycle
        if (i_cmd.mul_step) begin
            if (r_mb[0]) begin
                r_num <= r_num + r_ma;
            end
            r_ma <= r_ma << 1;
            r_mb <= r_mb >> 1;
        end
        // restoring divide, one quotient bit a cycle
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? 64'(w_trial - {1'b0, r_div}) : w_trial[63:0];
            r_quo <= {r_quo[78:0], w_ge};
            r_ovf <= r_ovf | r_quo[79];
        end
        // cordic rotation
        if (i_cmd.cor_step) begin
            if (!r_cz[33]) begin
                r_cx <= r_cx - w_dx;
                r_cy <= r_cy + w_dy;
                r_cz <= r_cz - w_at;
            end else begin
                r_cx <= r_cx + w_dx;
                r_cy <= r_cy - w_dy;
                r_cz <= r_cz + w_at;
            end
        end
        if (i_cmd.fin) begin
            case (i_cmd.job)
                odo_pkg::J_SW:   r_sw   <= r_num[48:0];
                odo_pkg::J_DW:   r_dw   <= r_num[48:0];
                odo_pkg::J_CT:   r_ct   <= r_num[47:0];
                odo_pkg::J_CDT:  r_cdt  <= r_num[39:0];
                odo_pkg::J_CTDT: r_ctdt <= r_num[63:0];
                odo_pkg::J_LIN: begin
                    r_lin_mag <= w_rnd[48:0];
                    r_lin_neg <= w_sum[24];
                end
                odo_pkg::J_LS: r_ls  <= sat32(w_rnd, w_ovf, w_sum[24]);
                odo_pkg::J_TR: r_tr  <= sat32(w_rnd, w_ovf, w_diff[24]);
                odo_pkg::J_RL: r_rl  <= sat32(w_rnd, w_ovf, r_dl[23]);
                odo_pkg::J_RR: r_rr  <= sat32(w_rnd, w_ovf, r_dr[23]);
                odo_pkg::J_AL: r_aal <= w_ainc;
                odo_pkg::J_AR: r_aar <= w_ainc;
                default: ;
            endcase
        end
        // result register
        if (i_cmd.out_load) begin
            r_o_data <= {24'(r_aar), 24'(r_aal),
                         w_dt_zero ? 32'd0 : r_rr,
                         w_dt_zero ? 32'd0 : r_rl,
                         w_dt_zero ? 32'd0 : r_tr,
                         w_dt_zero ? 32'd0 : r_ls,
                         24'(r_hd), 32'(r_y), 32'(r_x)};
            r_o_fault <= w_dt_zero;
        end
    end

    assign o_out_data  = r_o_data;
    assign o_out_fault = r_o_fault;

endmodule

// ===== rtl/odo_checker.sv =====
`include "assert_macros.svh"

module odo_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [263:0] m_axis_tdata,
    input logic [0:0]   m_axis_tuser
);

    // no result right after reset
    `ODO_ASSERT_RST(a_rst_no_valid, !i_rst_n |=> !m_axis_tvalid, "valid after reset")

    // a faulted time base gives zero speeds
    `ODO_ASSERT(a_fault_zero, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[215:88] == 128'd0, "speeds not zero on fault")

    // busy once an item is taken
    `ODO_ASSERT(a_busy, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "ready right after accept")

    // a stalled result holds
    `ODO_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind differential_drive_odometry odo_checker u_odo_checker (.*);

// ===== tb/differential_drive_odometry_tb.sv =====
`timescale 1ns / 1ps

module differential_drive_odometry_tb;

    // encoder report, last field in the lowest bits
    typedef struct packed {
        logic [15:0]        elapsed_ms;
        logic signed [31:0] left_abs;
        logic signed [31:0] right_abs;
        logic signed [23:0] left_delta;
        logic signed [23:0] right_delta;
    } t_report;

    // pose and speed item, last field in the lowest bits
    typedef struct packed {
        logic [23:0] ang_right;
        logic [23:0] ang_left;
        logic [31:0] rpm_right;
        logic [31:0] rpm_left;
        logic [31:0] turn_rate;
        logic [31:0] lin_speed;
        logic [23:0] heading;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
    } t_pose;

    typedef struct packed {
        logic  fault;
        t_pose pose;
    } t_pose_item;

    typedef struct packed {
        t_report rep;
        logic    typed;
    } t_row;

    localparam logic [63:0] INV_PI      = 64'h517CC1B727220A95;
    localparam longint      GAIN_Q30    = 652032874;
    localparam logic [63:0] RPM_SCALE   = 64'd120000000;
    localparam int          HOLD_CYCLES = 3000;
    localparam int          IDLE_LIMIT  = 20000;

    localparam longint ATAN_TURN [30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [263:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    differential_drive_odometry dut (.*);

    // predictor copy of configuration and pose
    logic [23:0] cfg_cpr;
    logic [23:0] cfg_circ;
    logic [23:0] cfg_track;
    logic [31:0] odo_x;
    logic [31:0] odo_y;
    logic [23:0] odo_heading;

    t_pose_item pose_expected [$];
    int         errors;
    int         reports_sent;
    int         poses_checked;
    int         faults_seen;
    int         burst_left;
    bit         gap_mode;
    int         rx_mode;
    bit         hold_req;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // round(a*b / (d*2^s)) on magnitudes, ties away from zero
    function automatic logic [191:0] round_ratio(input logic [191:0] a, input logic [191:0] b,
                                                 input logic [191:0] d, input int s);
        logic [191:0] p;
        p = (a * b) << 1;
        p = p / d;
        p = p >> s;
        p = p + 1;
        return p >> 1;
    endfunction

    function automatic logic [63:0] mag(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [31:0] sat_speed(input logic [191:0] m, input bit neg);
        logic [31:0] lim;
        logic [31:0] v;
        lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        v = (m > lim) ? lim : m[31:0];
        return neg ? -v : v;
    endfunction

    // sine and cosine of a heading, q30
    task automatic heading_sincos(input logic [23:0] ang, output longint cs, output longint sn);
        logic [31:0] th;
        bit          flip;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        th = {ang, 8'h00};
        flip = (th[31:30] == 2'd1) || (th[31:30] == 2'd2);
        if (flip) th = th + 32'h8000_0000;
        z = longint'(signed'(th));
        x = GAIN_Q30;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - ATAN_TURN[i];
            end else begin
                x = x + dx; y = y - dy; z = z + ATAN_TURN[i];
            end
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endtask

    // advance the pose by one report and build the expected item
    task automatic advance_pose(input t_report r, output t_pose_item e);
        longint       dr, dl, ar, al, sum, diff, lin, cs, sn;
        logic [63:0]  cc, tt, ww, dt;
        logic [191:0] m;
        dr = longint'(r.right_delta); dl = longint'(r.left_delta);
        ar = longint'(r.right_abs);   al = longint'(r.left_abs);
        dt = 64'(r.elapsed_ms);
        cc = (cfg_cpr == 0) ? 64'd1 : 64'(cfg_cpr);
        tt = (cfg_track == 0) ? 64'd1 : 64'(cfg_track);
        ww = 64'(cfg_circ);
        sum = dl + dr;
        diff = dr - dl;
        m = round_ratio(mag(sum), ww, cc, 1);
        lin = sum < 0 ? -longint'(m[63:0]) : longint'(m[63:0]);
        heading_sincos(odo_heading, cs, sn);
        m = round_ratio(mag(lin), mag(cs), 1, 30);
        odo_x = odo_x + (((lin < 0) != (cs < 0)) ? -m[31:0] : m[31:0]);
        m = round_ratio(mag(lin), mag(sn), 1, 30);
        odo_y = odo_y + (((lin < 0) != (sn < 0)) ? -m[31:0] : m[31:0]);
        m = round_ratio(mag(diff) * ww, INV_PI, cc * tt, 41);
        odo_heading = odo_heading + ((diff < 0) ? -m[23:0] : m[23:0]);
        e = '0;
        e.pose.pos_x = odo_x;
        e.pose.pos_y = odo_y;
        e.pose.heading = odo_heading;
        if (dt == 0) begin
            e.fault = 1'b1;
        end else begin
            e.pose.lin_speed = sat_speed(round_ratio(mag(sum) * ww, 1000, cc * dt, 1), sum < 0);
            e.pose.turn_rate = sat_speed(round_ratio(mag(diff) * ww, 1000000000,
                                                     192'(cc * tt) * dt, 0), diff < 0);
            e.pose.rpm_left = sat_speed(round_ratio(mag(dl), RPM_SCALE, cc * dt, 0), dl < 0);
            e.pose.rpm_right = sat_speed(round_ratio(mag(dr), RPM_SCALE, cc * dt, 0), dr < 0);
        end
        m = round_ratio(mag(al), 64'd1 << 24, cc, 0);
        e.pose.ang_left = (al < 0) ? -m[23:0] : m[23:0];
        m = round_ratio(mag(ar), 64'd1 << 24, cc, 0);
        e.pose.ang_right = (ar < 0) ? -m[23:0] : m[23:0];
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        if (errors <= 40)
            $display("mismatch on pose item %0d: %s got %h expected %h",
                     poses_checked, field, got, want);
    endtask

    // input side: bursts with random gaps in gap mode
    task automatic send_report(input t_report r, input bit typed, input t_pose_item typed_exp);
        t_pose_item e;
        if (gap_mode && burst_left <= 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = r;
        do @(posedge i_clk); while (!s_axis_tready);
        advance_pose(r, e);
        pose_expected.insert(pose_expected.size(), typed ? typed_exp : e);
        reports_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    function automatic t_report random_report();
        t_report r;
        int      kind;
        kind = $urandom_range(0, 19);
        r.right_abs = $urandom;
        r.left_abs = $urandom;
        if (kind < 4) begin
            r.right_delta = 24'($urandom);
            r.left_delta = 24'($urandom);
            r.elapsed_ms = 16'($urandom);
        end else begin
            r.right_delta = 24'($signed($urandom_range(0, 8000)) - 4000);
            r.left_delta = 24'($signed($urandom_range(0, 8000)) - 4000);
            r.elapsed_ms = 16'($urandom_range(5, 200));
        end
        if (kind == 19) r.elapsed_ms = 16'd0;
        if (kind == 18) r.left_delta = -r.right_delta;
        return r;
    endfunction

    task automatic reg_write(input logic [1:0] idx, input logic [23:0] val);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {idx, 2'b00}; pwdata = {8'h00, val};
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        pwrite = 1'b0; penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (prdata !== {8'h00, val}) report_mismatch("register readback", prdata, val);
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0;
        case (idx)
            odo_pkg::REG_CPR:   cfg_cpr = val;
            odo_pkg::REG_CIRC:  cfg_circ = val;
            odo_pkg::REG_TRACK: cfg_track = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pose_expected.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // output side: ready always, at random or in a fixed pattern, plus one long hold-off on request
    initial begin
        int hold_cnt;
        int pat;
        hold_cnt = 0;
        pat = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = HOLD_CYCLES;
            end
            pat++;
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_axis_tready = 1'b0;
            end else begin
                case (rx_mode)
                    0: m_axis_tready = 1'b1;
                    1: m_axis_tready = ($urandom_range(0, 3) != 0);
                    default: m_axis_tready = (pat % 11) < 7;
                endcase
            end
        end
    end

    // pose item check
    always @(posedge i_clk) begin
        t_pose_item g;
        t_pose_item e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            g = {m_axis_tuser, m_axis_tdata};
            if (pose_expected.size() == 0) begin
                report_mismatch("unexpected item", g.pose.pos_x, 0);
            end else begin
                e = pose_expected.pop_front();
                if (g.pose.pos_x !== e.pose.pos_x)
                    report_mismatch("pos_x_um", g.pose.pos_x, e.pose.pos_x);
                if (g.pose.pos_y !== e.pose.pos_y)
                    report_mismatch("pos_y_um", g.pose.pos_y, e.pose.pos_y);
                if (g.pose.heading !== e.pose.heading)
                    report_mismatch("heading", g.pose.heading, e.pose.heading);
                if (g.pose.lin_speed !== e.pose.lin_speed)
                    report_mismatch("linear_speed_um_s", g.pose.lin_speed, e.pose.lin_speed);
                if (g.pose.turn_rate !== e.pose.turn_rate)
                    report_mismatch("turn_rate_urad_s", g.pose.turn_rate, e.pose.turn_rate);
                if (g.pose.rpm_left !== e.pose.rpm_left)
                    report_mismatch("left_rpm_centi", g.pose.rpm_left, e.pose.rpm_left);
                if (g.pose.rpm_right !== e.pose.rpm_right)
                    report_mismatch("right_rpm_centi", g.pose.rpm_right, e.pose.rpm_right);
                if (g.pose.ang_left !== e.pose.ang_left)
                    report_mismatch("left_wheel_angle", g.pose.ang_left, e.pose.ang_left);
                if (g.pose.ang_right !== e.pose.ang_right)
                    report_mismatch("right_wheel_angle", g.pose.ang_right,
                                    e.pose.ang_right);
                if (g.fault !== e.fault)
                    report_mismatch("time_fault", g.fault, e.fault);
                if (e.fault) faults_seen++;
            end
            poses_checked++;
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        int idle_cycles;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_row        rows [$];
        t_pose_item  zero_item;
        t_pose_item  fault_item;
        logic [23:0] settings [7][3];
        t_report     r;

        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        errors = 0; reports_sent = 0; poses_checked = 0; faults_seen = 0;
        burst_left = 0; gap_mode = 1'b0; rx_mode = 0; hold_req = 1'b0;
        cfg_cpr = 24'd200000; cfg_circ = 24'd565486; cfg_track = 24'd815000;
        odo_x = '0; odo_y = '0; odo_heading = '0;

        settings = '{
            '{24'd1,        24'd1,        24'd1},
            '{24'hFFFFFF,   24'hFFFFFF,   24'hFFFFFF},
            '{24'd0,        24'd0,        24'd0},
            '{24'd1,        24'hFFFFFF,   24'd1},
            '{24'hFFFFFF,   24'd1,        24'hFFFFFF},
            '{24'd4096,     24'd314159,   24'd500000},
            '{24'd200000,   24'd565486,   24'd815000}
        };

        zero_item = '0;
        fault_item = '0;
        fault_item.fault = 1'b1;

        // directed reports: fields, extremes, quadrant sweep of the heading
        rows.insert(rows.size(), '{'{16'd0, 0, 0, 0, 0}, 1'b1});
        rows.insert(rows.size(), '{'{16'd5, 0, 0, 0, 0}, 1'b1});
        rows.insert(rows.size(),
                    '{'{16'd1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 24'sh7FFFFF, 24'sh7FFFFF}, 1'b0});
        rows.insert(rows.size(),
                    '{'{16'd1, 32'sh80000000, 32'sh80000000, 24'sh800000, 24'sh800000}, 1'b0});
        rows.insert(rows.size(), '{'{16'hFFFF, 0, 0, 24'sh800000, 24'sh7FFFFF}, 1'b0});
        rows.insert(rows.size(), '{'{16'hFFFF, 1, -1, 24'sh7FFFFF, 24'sh800000}, 1'b0});
        rows.insert(rows.size(), '{'{16'd20, -12345, 12345, 1000, 1000}, 1'b0});
        rows.insert(rows.size(), '{'{16'd20, 0, 0, -1000, -1000}, 1'b0});
        rows.insert(rows.size(), '{'{16'd0, 0, 0, -5000, 5000}, 1'b0});
        rows.insert(rows.size(), '{'{16'd50, -200000, 200000, 0, 200000}, 1'b0});
        rows.insert(rows.size(), '{'{16'd50, 100000, 100000, 100000, 0}, 1'b0});
        for (int q = 0; q < 4; q++) begin
            rows.insert(rows.size(), '{'{16'd40, 0, 0, -226400, 226400}, 1'b0});
            rows.insert(rows.size(), '{'{16'd40, 0, 0, 3000, 3000}, 1'b0});
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        gap_mode = 1'b1;
        rx_mode = 1;
        foreach (rows[k])
            send_report(rows[k].rep, rows[k].typed, (k == 0) ? fault_item : zero_item);
        for (int n = 0; n < 90; n++) send_report(random_report(), 1'b0, zero_item);
        drain();

        for (int p = 0; p < 7; p++) begin
            reg_write(odo_pkg::REG_CPR, settings[p][0]);
            reg_write(odo_pkg::REG_CIRC, settings[p][1]);
            reg_write(odo_pkg::REG_TRACK, settings[p][2]);
            gap_mode = (p % 3) != 0;
            rx_mode = p % 3;
            @(negedge i_clk);
            if (p == 5) hold_req = 1'b1;
            for (int n = 0; n < 85; n++) send_report(random_report(), 1'b0, zero_item);
            drain();
        end

        repeat (1000) @(negedge i_clk);
        $display("covered %0d encoder reports, %0d zero-time faults, reset and seven written register settings",
                 reports_sent, faults_seen);
        $display("including zero and full-scale registers and one long output stall");
        if (errors == 0 && pose_expected.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
